>>> rtl/core/wsc_pkg.sv
package wsc_pkg;

  // fixed field widths of the request and result ports
  localparam int OPCODE_W  = 1;
  localparam int CASE_W    = 4;
  localparam int WEIGHT_W  = 16;
  localparam int RAND_W    = 16;
  localparam int TOTAL_W   = 20;
  localparam int ACTIVE_W  = 5;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_ACTIVE_CASES = 1'b0;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  // request opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_PRIME,
    ST_SUM_WALK,
    ST_WR_READ,
    ST_WR_UPDATE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DRAW_WALK,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic sum_start;
    logic sum_step;
    logic wr_read;
    logic wr_update;
    logic mul_lo;
    logic mul_hi;
    logic draw_step;
  } dp_cmd_t;

  typedef struct packed {
    logic dirty;
    logic op_draw;
    logic walk_last;
    logic walk_hit;
  } dp_status_t;

endpackage

>>> rtl/core/wsc_ram.sv
module wsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/wsc_ctrl.sv
module wsc_ctrl
  import wsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OPCODE_W-1:0] opcode,
  input  dp_status_t          sts,
  output dp_cmd_t             cmd,
  output logic                busy,
  output logic                done
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    done       = (state == ST_DONE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          // a stale total is rebuilt before the request itself runs
          if (sts.dirty) begin
            state_next = ST_SUM_PRIME;
          end else if (opcode == OP_DRAW) begin
            state_next = ST_MUL_LO;
          end else begin
            state_next = ST_WR_READ;
          end
        end
      end
      ST_SUM_PRIME: begin
        cmd.sum_start = 1'b1;
        state_next    = ST_SUM_WALK;
      end
      ST_SUM_WALK: begin
        cmd.sum_step = 1'b1;
        if (sts.walk_last) begin
          state_next = sts.op_draw ? ST_MUL_LO : ST_WR_READ;
        end
      end
      ST_WR_READ: begin
        cmd.wr_read = 1'b1;
        state_next  = ST_WR_UPDATE;
      end
      ST_WR_UPDATE: begin
        cmd.wr_update = 1'b1;
        state_next    = ST_DONE;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_DRAW_WALK;
      end
      ST_DRAW_WALK: begin
        cmd.draw_step = 1'b1;
        if (sts.walk_hit || sts.walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/wsc_datapath.sv
module wsc_datapath
  import wsc_pkg::*;
#(
  parameter int MAX_CASES   = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int RAND_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_status_t          sts,
  input  logic                cfg_changed,
  input  logic [ACTIVE_W-1:0] active_cases,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [CASE_W-1:0]   case_index,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [RAND_W-1:0]   random_fraction,
  output logic                was_draw,
  output logic [CASE_W-1:0]   chosen_case,
  output logic [WEIGHT_W-1:0] chosen_weight,
  output logic [TOTAL_W-1:0]  weight_total
);

  localparam int AW = $clog2(MAX_CASES);
  localparam int CW = $clog2(MAX_CASES + 1);
  localparam int IW = (AW > CASE_W) ? AW : CASE_W;
  localparam int TW = WEIGHT_BITS + AW;
  localparam int PW = RAND_BITS + TW;
  localparam int LO = (TW + 1) / 2;
  localparam int HI = TW - LO;

  logic                   op_q;
  logic [IW-1:0]          idx_q;
  logic                   in_range_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [RAND_BITS-1:0]   r_q;
  logic [TW-1:0]          total;
  logic                   dirty;
  logic [TW-1:0]          cum;
  logic [AW-1:0]          cidx;
  logic [PW-1:0]          prod;
  logic [AW-1:0]          chosen_q;
  logic [WEIGHT_BITS-1:0] chosen_w;
  logic [MAX_CASES-1:0]   valid;
  logic                   rdv;

  logic [CW-1:0]          n_eff;
  logic [AW-1:0]          last_idx;
  logic [AW-1:0]          raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic [WEIGHT_BITS-1:0] w_rd;
  logic [TW-1:0]          cum_next;
  logic [TW-1:0]          thr;
  logic [RAND_BITS+LO-1:0] pp_lo;
  logic [RAND_BITS+HI-1:0] pp_hi;
  logic                   ram_we;
  logic                   wr_counts;

  // zero means one case, anything above the table size saturates
  always_comb begin
    if (active_cases == '0) begin
      n_eff = CW'(1);
    end else if (32'(active_cases) > MAX_CASES) begin
      n_eff = CW'(MAX_CASES);
    end else begin
      n_eff = CW'(active_cases);
    end
  end

  assign last_idx = AW'(n_eff - CW'(1));

  always_comb begin
    if (cmd.sum_step || cmd.draw_step) begin
      raddr = cidx + AW'(1);
    end else if (cmd.wr_read) begin
      raddr = idx_q[AW-1:0];
    end else begin
      raddr = '0;
    end
  end

  // an entry never written reads as zero
  assign w_rd      = rdv ? rdata : '0;
  assign cum_next  = cum + TW'(w_rd);
  // r*total < cum*2^R  <=>  floor(r*total / 2^R) < cum
  assign thr       = prod[PW-1:RAND_BITS];
  assign pp_lo     = r_q * total[LO-1:0];
  assign pp_hi     = r_q * total[TW-1:LO];
  assign ram_we    = cmd.wr_update && in_range_q;
  assign wr_counts = 32'(idx_q) < 32'(n_eff);

  assign sts.dirty     = dirty;
  assign sts.op_draw   = op_q;
  assign sts.walk_last = (cidx == last_idx);
  assign sts.walk_hit  = (thr < cum_next);

  wsc_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_CASES)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_q[AW-1:0]),
    .wdata (w_q),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= 1'b0;
      total <= '0;
      rdv   <= 1'b0;
    end else begin
      rdv <= (32'(raddr) < MAX_CASES) ? valid[raddr] : 1'b0;
      if (ram_we) begin
        valid[idx_q[AW-1:0]] <= 1'b1;
      end
      if (cfg_changed) begin
        dirty <= 1'b1;
      end
      if (cmd.sum_step && sts.walk_last) begin
        total <= cum_next;
        dirty <= 1'b0;
      end
      if (cmd.wr_update && in_range_q && wr_counts) begin
        total <= total - TW'(w_rd) + TW'(w_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= (opcode == OP_DRAW);
      idx_q      <= IW'(case_index);
      in_range_q <= 32'(case_index) < MAX_CASES;
      w_q        <= WEIGHT_BITS'(weight);
      r_q        <= RAND_BITS'(random_fraction);
    end
    if (cmd.sum_start || cmd.mul_lo) begin
      cum  <= '0;
      cidx <= '0;
    end
    if (cmd.sum_step || cmd.draw_step) begin
      cum  <= cum_next;
      cidx <= cidx + AW'(1);
    end
    if (cmd.mul_lo) begin
      prod <= PW'(pp_lo);
    end
    if (cmd.mul_hi) begin
      prod <= prod + (PW'(pp_hi) << LO);
    end
    // on a hit or at the last active case the current entry is the answer
    if (cmd.draw_step) begin
      chosen_q <= cidx;
      chosen_w <= w_rd;
    end
    if (cmd.wr_update) begin
      chosen_q <= '0;
      chosen_w <= in_range_q ? w_q : '0;
    end
  end

  assign was_draw      = op_q;
  assign chosen_case   = CASE_W'(chosen_q);
  assign chosen_weight = WEIGHT_W'(chosen_w);
  assign weight_total  = TOTAL_W'(total);

endmodule

>>> rtl/core/weighted_case_sampler_unit.sv
// weighted case sampler: roulette-wheel draw over a table of case weights
// a weight write strobes done once the table entry is updated; a draw strobes done once
//   the walk hits or reaches the last active case, sooner when an earlier case is chosen
// a new request is taken only after done; the walk reads one weight per cycle, and the
//   first request after an active_cases write first rebuilds the total by such a walk
// reset: synchronous, clears all weights and sets active_cases to 16; done is never held off
module weighted_case_sampler_unit
  import wsc_pkg::*;
#(
  parameter int MAX_CASES   = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int RAND_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [OPCODE_W-1:0]   opcode,
  input  logic [CASE_W-1:0]     case_index,
  input  logic [WEIGHT_W-1:0]   weight,
  input  logic [RAND_W-1:0]     random_fraction,
  output logic                  done,
  output logic                  was_draw,
  output logic [CASE_W-1:0]     chosen_case,
  output logic [WEIGHT_W-1:0]   chosen_weight,
  output logic [TOTAL_W-1:0]    weight_total
);

  logic [ACTIVE_W-1:0] active_cases;
  logic                cfg_wr;
  dp_cmd_t             cmd;
  dp_status_t          sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_CASES);
  assign prdata = (paddr[2] == REG_ACTIVE_CASES) ? APB_DATA_W'(active_cases) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cases <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_cases <= pwdata[ACTIVE_W-1:0];
    end
  end

  wsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  wsc_datapath #(
    .MAX_CASES   (MAX_CASES),
    .WEIGHT_BITS (WEIGHT_BITS),
    .RAND_BITS   (RAND_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_changed     (cfg_wr),
    .active_cases    (active_cases),
    .opcode          (opcode),
    .case_index      (case_index),
    .weight          (weight),
    .random_fraction (random_fraction),
    .was_draw        (was_draw),
    .chosen_case     (chosen_case),
    .chosen_weight   (chosen_weight),
    .weight_total    (weight_total)
  );

endmodule
